// ===== sv/flptb_pkg.sv =====
// Shared types, constants and helpers of the four-level page table builder.
`default_nettype none

package flptb_pkg;

  // Default number of pool pages behind the root page
  localparam int unsigned POOL_PAGES_DEF = 63;

  localparam int unsigned LEVELS     = 4;
  localparam int unsigned IDX_W      = 9;
  localparam int unsigned ENTRIES    = 512;
  localparam int unsigned ADDR_W     = 48;
  localparam int unsigned PAGE_OFS_W = 12;
  localparam int unsigned FRAME_W    = 36;
  localparam int unsigned ENTRY_W    = 64;
  localparam int unsigned MT_W       = 3;
  localparam int unsigned LVL_W      = 2;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned PAGES_W    = 6;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = FRAME_W;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_FRAME = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MEM_TYPE   = 2'd1;
  localparam logic [MT_W-1:0]      MEM_TYPE_RST   = 3'd6;

  // Request opcodes
  localparam logic OP_MAP    = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  localparam logic [2:0] RWX_BITS = 3'b111;
  localparam logic [LVL_W-1:0] LEAF_LEVEL = 2'd3;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_EXHAUSTED  = 2'd1,
    ST_NOT_MAPPED = 2'd2
  } status_e;

  // Source of the leaf field of a result
  typedef enum logic [1:0] {
    LEAF_ZERO,
    LEAF_NEW,
    LEAF_READ
  } leaf_sel_e;

  // Controller to datapath commands
  typedef struct packed {
    logic      accept;
    logic      clr_en;
    logic      rd_en;
    logic      alloc;
    logic      follow;
    logic      leaf_wr;
    logic      finish;
    status_e   fin_status;
    leaf_sel_e fin_leaf;
    logic      push;
  } flptb_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clr_last;
    logic entry_zero;
    logic pool_full;
    logic link_bad;
    logic lookup;
    logic last_level;
    logic out_free;
  } flptb_sts_t;

  // 9-bit table index of one level from address bits 47:12
  function automatic logic [IDX_W-1:0] level_index(input logic [FRAME_W-1:0] frame,
                                                   input logic [LVL_W-1:0] lvl);
    logic [IDX_W-1:0] idx;
    case (lvl)
      2'd0:    idx = frame[35:27];
      2'd1:    idx = frame[26:18];
      2'd2:    idx = frame[17:9];
      default: idx = frame[8:0];
    endcase
    return idx;
  endfunction

endpackage

`default_nettype wire

// ===== sv/flptb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module flptb_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 32768
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== sv/flptb_ctrl.sv =====
// Controller of the page table walker: clearing pass, level walk, result hand-off.
`default_nettype none

module flptb_ctrl
  import flptb_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire flptb_sts_t sts_i,
  output flptb_cmd_t      cmd_o
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RD,
    S_EVAL,
    S_DONE
  } state_e;

  state_e state_q, state_d;

  // Next state and command decode
  always_comb begin
    state_d            = state_q;
    cmd_o              = '0;
    cmd_o.fin_status   = ST_OK;
    cmd_o.fin_leaf     = LEAF_ZERO;
    in_ready_o         = 1'b0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_en = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_RD;
        end
      end
      S_RD: begin
        if (sts_i.last_level && !sts_i.lookup) begin
          // map leaf: written without reading
          cmd_o.leaf_wr    = 1'b1;
          cmd_o.finish     = 1'b1;
          cmd_o.fin_status = ST_OK;
          cmd_o.fin_leaf   = LEAF_NEW;
          state_d          = S_DONE;
        end else begin
          cmd_o.rd_en = 1'b1;
          state_d     = S_EVAL;
        end
      end
      S_EVAL: begin
        if (sts_i.last_level) begin
          cmd_o.finish     = 1'b1;
          cmd_o.fin_status = ST_OK;
          cmd_o.fin_leaf   = LEAF_READ;
          state_d          = S_DONE;
        end else if (sts_i.entry_zero) begin
          if (sts_i.lookup) begin
            cmd_o.finish     = 1'b1;
            cmd_o.fin_status = ST_NOT_MAPPED;
            state_d          = S_DONE;
          end else if (sts_i.pool_full) begin
            cmd_o.finish     = 1'b1;
            cmd_o.fin_status = ST_EXHAUSTED;
            state_d          = S_DONE;
          end else begin
            cmd_o.alloc = 1'b1;
            state_d     = S_RD;
          end
        end else if (sts_i.link_bad) begin
          cmd_o.finish     = 1'b1;
          cmd_o.fin_status = ST_NOT_MAPPED;
          state_d          = S_DONE;
        end else begin
          cmd_o.follow = 1'b1;
          state_d      = S_RD;
        end
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.push = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/flptb_dp.sv =====
// Datapath: table store, pool counter, config registers, walk registers, result register.
`default_nettype none

module flptb_dp
  import flptb_pkg::*;
#(
  parameter int unsigned POOL_PAGES = POOL_PAGES_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire flptb_cmd_t            cmd_i,
  output flptb_sts_t                 sts_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic                  req_op_i,
  input  wire logic [ADDR_W-1:0]     req_addr_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [STATUS_W-1:0]        out_status_o,
  output logic [ENTRY_W-1:0]         out_leaf_o,
  output logic [PAGES_W-1:0]         out_pages_o
);

  localparam int unsigned PW    = $clog2(POOL_PAGES + 1);
  localparam int unsigned DEPTH = (POOL_PAGES + 1) * ENTRIES;
  localparam int unsigned AW    = $clog2(DEPTH);

  // Configuration registers
  logic [FRAME_W-1:0] base_q;
  logic [MT_W-1:0]    mt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
      mt_q   <= MEM_TYPE_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_BASE_FRAME) begin
        base_q <= cfg_wdata_i;
      end else if (cfg_idx_i == CFG_MEM_TYPE) begin
        mt_q <= cfg_wdata_i[MT_W-1:0];
      end
    end
  end

  // Walk registers
  logic                op_q;
  logic [FRAME_W-1:0]  vfn_q;
  logic [PW-1:0]       page_q;
  logic [LVL_W-1:0]    lvl_q;
  logic [PW-1:0]       used_q;
  logic [AW-1:0]       clr_cnt_q;

  logic [ENTRY_W-1:0]  rdata;
  logic [AW-1:0]       slot;
  logic [PW-1:0]       used_inc;
  logic [FRAME_W-1:0]  new_frame;
  logic [ENTRY_W-1:0]  new_entry;
  logic [ENTRY_W-1:0]  leaf_val;
  logic [FRAME_W-1:0]  rel;

  assign slot      = {page_q, level_index(vfn_q, lvl_q)};
  assign used_inc  = used_q + 1'b1;
  assign new_frame = base_q + FRAME_W'(used_inc);
  assign new_entry = {16'b0, new_frame, 9'b0, RWX_BITS};
  assign leaf_val  = {16'b0, vfn_q, 6'b0, mt_q, RWX_BITS};
  // page number that a stored link points at, relative to the table base
  assign rel       = rdata[ADDR_W-1:PAGE_OFS_W] - base_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
      used_q    <= '0;
      page_q    <= '0;
      lvl_q     <= '0;
    end else begin
      if (cmd_i.clr_en) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
      if (cmd_i.accept) begin
        page_q <= '0;
        lvl_q  <= '0;
      end else if (cmd_i.alloc) begin
        used_q <= used_inc;
        page_q <= used_inc;
        lvl_q  <= lvl_q + 1'b1;
      end else if (cmd_i.follow) begin
        page_q <= rel[PW-1:0];
        lvl_q  <= lvl_q + 1'b1;
      end
    end
  end

  // Request payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q  <= req_op_i;
      vfn_q <= req_addr_i[ADDR_W-1:PAGE_OFS_W];
    end
  end

  // Table store
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;

  assign ram_we    = cmd_i.clr_en | cmd_i.alloc | cmd_i.leaf_wr;
  assign ram_waddr = cmd_i.clr_en ? clr_cnt_q : slot;
  assign ram_wdata = cmd_i.clr_en ? '0 : (cmd_i.alloc ? new_entry : leaf_val);

  flptb_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.rd_en),
    .raddr_i (slot),
    .rdata_o (rdata)
  );

  // Pending result
  logic [STATUS_W-1:0] res_status_q;
  logic [ENTRY_W-1:0]  res_leaf_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      res_status_q <= cmd_i.fin_status;
      case (cmd_i.fin_leaf)
        LEAF_NEW:  res_leaf_q <= leaf_val;
        LEAF_READ: res_leaf_q <= rdata;
        default:   res_leaf_q <= '0;
      endcase
    end
  end

  // Output register
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.push) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      out_status_o <= res_status_q;
      out_leaf_o   <= res_leaf_q;
      out_pages_o  <= PAGES_W'(used_q);
    end
  end

  assign out_valid_o = out_valid_q;

  // Status to the controller
  assign sts_o.clr_last   = (clr_cnt_q == AW'(DEPTH - 1));
  assign sts_o.entry_zero = (rdata == '0);
  assign sts_o.pool_full  = (used_q >= PW'(POOL_PAGES));
  assign sts_o.link_bad   = (rel > FRAME_W'(POOL_PAGES));
  assign sts_o.lookup     = (op_q == OP_LOOKUP);
  assign sts_o.last_level = (lvl_q == LEAF_LEVEL);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

`ifndef SYNTHESIS
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= PW'(POOL_PAGES))
    else $error("pool counter beyond pool size");

  a_alloc_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.alloc |-> !sts_o.pool_full)
    else $error("page allocated from a full pool");

  a_push_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |=> out_valid_q)
    else $error("result push not seen at output");

  a_clear_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clr_en |-> !(cmd_i.alloc || cmd_i.leaf_wr || cmd_i.accept))
    else $error("table write during clearing pass");
`endif

endmodule

`default_nettype wire

// ===== sv/four_level_page_table_builder_unit.sv =====
// Top level of the four-level page table builder: controller plus datapath.
// After reset the table store is swept to zero, one entry per cycle, over
// all (POOL_PAGES+1)*512 entries (32768 at the default of 63 pool pages); no request
// is accepted during that pass, configuration writes are. Each request walks
// four levels in one synchronous memory: every upper level passes a read state
// (address) and an evaluate state (registered read), and a missing table is
// written in the evaluate state; the map leaf is written in the read state without
// reading, the lookup leaf is read there and returned from the evaluate state;
// requests that stop early skip the remaining levels.
// One request is worked on at a time; the next is taken while the previous
// result still waits in the output register.
`default_nettype none

module four_level_page_table_builder_unit
  import flptb_pkg::*;
#(
  parameter int unsigned POOL_PAGES = POOL_PAGES_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // configuration write port
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  // request stream
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [47:0]           s_axis_tdata,  // guest_phys_addr[47:0]
  input  wire logic [0:0]            s_axis_tuser,  // opcode[0]
  // result stream
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [71:0]                m_axis_tdata   // status[1:0], leaf_entry[65:2],
                                                    // pages_in_use[71:66]
);

  flptb_cmd_t cmd;
  flptb_sts_t sts;

  logic [STATUS_W-1:0] out_status;
  logic [ENTRY_W-1:0]  out_leaf;
  logic [PAGES_W-1:0]  out_pages;

  flptb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  flptb_dp #(
    .POOL_PAGES (POOL_PAGES)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .req_op_i     (s_axis_tuser[0]),
    .req_addr_i   (s_axis_tdata),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_status_o (out_status),
    .out_leaf_o   (out_leaf),
    .out_pages_o  (out_pages)
  );

  // result fields packed from the low bit up
  assign m_axis_tdata = {out_pages, out_leaf, out_status};

endmodule

`default_nettype wire

// ===== sim/four_level_page_table_builder_unit_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of the four-level page table builder unit.
module four_level_page_table_builder_unit_test;
  import flptb_pkg::*;

  localparam int unsigned POOL        = POOL_PAGES_DEF;
  localparam int unsigned TABLE_SLOTS = (POOL + 1) * ENTRIES;
  localparam int unsigned CYCLE_LIMIT = 600_000;
  localparam int unsigned LONG_HOLD   = 300;
  localparam int unsigned PHASES      = 5;
  localparam int unsigned PHASE_ITEMS = 167;
  localparam int unsigned TAIL_CYCLES = 20;

  // register index outside the list; writes to it must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;

  localparam logic [FRAME_W-1:0] FAR_BASE = 36'h0_0000_1000;
  localparam logic [FRAME_W-1:0] TOP_BASE = '1;
  localparam logic [ADDR_W-1:0]  ALL_ONES = '1;

  // one result transaction, same bit order as m_axis_tdata
  typedef struct packed {
    logic [PAGES_W-1:0] pages_in_use;
    logic [ENTRY_W-1:0] leaf_entry;
    status_e            status;
  } walk_result_t;

  // Shadow copy of the table store plus the queue of outstanding walk results
  class walk_scoreboard;
    logic [ENTRY_W-1:0] shadow_tables [TABLE_SLOTS];
    int unsigned        pages_used;
    logic [FRAME_W-1:0] base_frame;
    logic [MT_W-1:0]    leaf_type;
    walk_result_t       results_due[$];
    logic [ADDR_W-1:0]  mapped_addrs[$];
    int unsigned        errors;

    function new();
      foreach (shadow_tables[i]) shadow_tables[i] = '0;
      pages_used = 0;
      base_frame = '0;
      leaf_type  = MEM_TYPE_RST;
      errors     = 0;
    endfunction

    function void write_reg(input logic [CFG_IDX_W-1:0] idx,
                            input logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_BASE_FRAME) base_frame = data[FRAME_W-1:0];
      else if (idx == CFG_MEM_TYPE) leaf_type = data[MT_W-1:0];
    endfunction

    // Walks the shadow tables for one accepted request and queues its result
    function void walk_request(input logic op, input logic [ADDR_W-1:0] addr);
      int unsigned        page;
      int unsigned        slot;
      logic [ENTRY_W-1:0] entry;
      logic [FRAME_W-1:0] frame;
      logic [FRAME_W-1:0] rel;
      walk_result_t       res;
      page       = 0;
      res.status = ST_OK;
      res.leaf_entry = '0;
      for (int lvl = 0; lvl < LEVELS - 1; lvl++) begin
        slot  = page * ENTRIES + int'(addr[(39 - 9 * lvl) +: IDX_W]);
        entry = shadow_tables[slot];
        if (entry == '0) begin
          if (op == OP_LOOKUP) begin
            res.status = ST_NOT_MAPPED;
            break;
          end
          if (pages_used >= POOL) begin
            res.status = ST_EXHAUSTED;
            break;
          end
          // new table: next pool page, frame counted from the base
          pages_used++;
          frame = base_frame + FRAME_W'(pages_used);
          entry = {16'h0, frame, 9'h0, RWX_BITS};
          shadow_tables[slot] = entry;
        end
        // links that land outside the store are not followed
        rel = entry[47:12] - base_frame;
        if (rel > POOL) begin
          res.status = ST_NOT_MAPPED;
          break;
        end
        page = int'(rel);
      end
      if (res.status == ST_OK) begin
        slot = page * ENTRIES + int'(addr[20:12]);
        if (op == OP_LOOKUP) begin
          res.leaf_entry = shadow_tables[slot];
        end else begin
          res.leaf_entry = {16'h0, addr[47:12], 6'h0, leaf_type, RWX_BITS};
          shadow_tables[slot] = res.leaf_entry;
          mapped_addrs.push_back(addr);
        end
      end
      res.pages_in_use = pages_used[PAGES_W-1:0];
      results_due.push_back(res);
    endfunction

    function void check_result(input logic [71:0] beat);
      walk_result_t got;
      walk_result_t want;
      got = walk_result_t'(beat);
      if (results_due.size() == 0) begin
        $error("result transaction with nothing outstanding: %h", beat);
        errors++;
        return;
      end
      want = results_due.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.leaf_entry !== want.leaf_entry) begin
        $error("leaf_entry: expected %h, got %h", want.leaf_entry, got.leaf_entry);
        errors++;
      end
      if (got.pages_in_use !== want.pages_in_use) begin
        $error("pages_in_use: expected %0d, got %0d", want.pages_in_use,
               got.pages_in_use);
        errors++;
      end
    endfunction
  endclass

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i     = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i   = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [47:0]           s_axis_tdata  = '0;  // guest_phys_addr[47:0]
  logic [0:0]            s_axis_tuser  = '0;  // opcode[0]
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [71:0]           m_axis_tdata;        // status[1:0], leaf_entry[65:2],
                                              // pages_in_use[71:66]
  logic                  hold_request  = 1'b0;
  int unsigned           cycle_count   = 0;
  walk_scoreboard        scb;

  four_level_page_table_builder_unit #(
    .POOL_PAGES(POOL)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Timeout
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) scb.check_result(m_axis_tdata);
  end

  // Result sink: runs of ready and stall, mostly short; one long hold on request
  initial begin : result_sink
    int unsigned r;
    int unsigned span;
    @(negedge clk_i);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk_i);
      end else begin
        r = $urandom_range(99);
        if (r < 45) begin
          m_axis_tready <= 1'b1;
          span = $urandom_range(8, 1);
        end else if (r < 55) begin
          m_axis_tready <= 1'b1;
          span = $urandom_range(150, 40);
        end else if (r < 90) begin
          m_axis_tready <= 1'b0;
          span = $urandom_range(3, 1);
        end else begin
          m_axis_tready <= 1'b0;
          span = $urandom_range(40, 10);
        end
        repeat (span) @(negedge clk_i);
      end
    end
  end

  // Entered and left at a falling edge; valid stays up between back-to-back requests
  task automatic send_request(input logic op, input logic [ADDR_W-1:0] addr,
                              input int unsigned gap);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= addr;
    s_axis_tuser  <= op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    scb.walk_request(op, addr);
    @(negedge clk_i);
  endtask

  // Writes both registers and a spare index; only while the block is idle
  task automatic write_config(input logic [FRAME_W-1:0] base,
                              input logic [MT_W-1:0] mtype);
    logic [CFG_DATA_W-1:0] junk;
    junk = CFG_DATA_W'({$urandom(), $urandom()});
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_BASE_FRAME;
    cfg_wdata_i <= base;
    scb.write_reg(CFG_BASE_FRAME, base);
    @(negedge clk_i);
    cfg_idx_i   <= CFG_MEM_TYPE;
    cfg_wdata_i <= {junk[CFG_DATA_W-1:MT_W], mtype};
    scb.write_reg(CFG_MEM_TYPE, {junk[CFG_DATA_W-1:MT_W], mtype});
    @(negedge clk_i);
    cfg_idx_i   <= CFG_IDX_SPARE;
    cfg_wdata_i <= junk;
    scb.write_reg(CFG_IDX_SPARE, junk);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Drops valid so the last request is not taken twice, then waits for all results
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (scb.results_due.size() != 0) @(negedge clk_i);
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(40, 20);
  endfunction

  // Mostly addresses that share upper tables with ones already mapped
  function automatic logic [ADDR_W-1:0] pick_address();
    int unsigned       r;
    logic [ADDR_W-1:0] fresh;
    logic [ADDR_W-1:0] known;
    r = $urandom_range(99);
    fresh[47:16] = $urandom();
    fresh[15:0]  = 16'($urandom());
    if (scb.mapped_addrs.size() == 0 || r < 15) return fresh;
    known = scb.mapped_addrs[$urandom_range(scb.mapped_addrs.size() - 1)];
    if (r < 30) return {known[47:39], fresh[38:0]};
    if (r < 50) return {known[47:30], fresh[29:0]};
    if (r < 85) return {known[47:21], fresh[20:0]};
    return known;
  endfunction

  initial begin : stimulus
    logic [FRAME_W-1:0] phase_base [PHASES];
    logic [MT_W-1:0]    phase_type [PHASES];
    logic               op;
    int unsigned        burst_left;
    scb = new();
    phase_base = '{36'd0, 36'd0, TOP_BASE, 36'd3, 36'd0};
    phase_type = '{3'd7, 3'd0, 3'd6, 3'd3, 3'd5};
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty root, first maps, zero leaf, pattern addresses (reset config)
    send_request(OP_LOOKUP, '0, 0);
    send_request(OP_MAP, '0, 0);
    send_request(OP_LOOKUP, '0, 0);
    send_request(OP_MAP, ALL_ONES, 0);
    send_request(OP_LOOKUP, ALL_ONES, 1);
    send_request(OP_LOOKUP, {ALL_ONES[47:21], 21'h0}, 0);
    send_request(OP_MAP, 48'hAAAA_AAAA_AAAA, 0);
    send_request(OP_MAP, 48'h5555_5555_5555, 2);
    send_request(OP_MAP, 48'h0000_0000_1000, 0);
    send_request(OP_MAP, '0, 0);
    send_request(OP_LOOKUP, 48'h8000_0000_0000, 0);
    send_request(OP_LOOKUP, 48'h0000_0000_1000, 0);

    // Base moved far away: existing links point outside the store
    wait_drained();
    write_config(FAR_BASE, 3'd0);
    send_request(OP_LOOKUP, '0, 0);
    send_request(OP_MAP, ALL_ONES, 0);
    send_request(OP_MAP, 48'h0123_4567_89AB, 0);
    send_request(OP_LOOKUP, 48'h0123_4567_89AB, 0);

    // Base at its top value: links shift by one page
    wait_drained();
    write_config(TOP_BASE, 3'd7);
    send_request(OP_LOOKUP, '0, 0);
    send_request(OP_MAP, '0, 0);
    send_request(OP_LOOKUP, ALL_ONES, 0);
    send_request(OP_MAP, 48'h5555_5555_5555, 0);

    // Random phases, one register setting each
    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      write_config(phase_base[p], phase_type[p]);
      burst_left = 25;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 0 && n == 50) begin
          hold_request = 1'b1;
          burst_left   = 25;
        end
        op = ($urandom_range(99) < 45) ? OP_LOOKUP : OP_MAP;
        send_request(op, pick_address(), (burst_left > 0) ? 0 : pick_gap());
        if (burst_left > 0) burst_left--;
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (scb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/flptb_pkg.sv
sv/flptb_ram.sv
sv/flptb_ctrl.sv
sv/flptb_dp.sv
sv/four_level_page_table_builder_unit.sv
sim/four_level_page_table_builder_unit_test.sv
